/* hw/rtl/arpc_pkg.sv */
// shared types and constants of the arp cache with pending queue
package arpc_pkg;

  // payload widths
  localparam int unsigned IP_W     = 32;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned HANDLE_W = 8;
  localparam int unsigned STAMP_W  = 16;
  localparam int unsigned AGE_W    = 8;

  // configuration port
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam int unsigned CFG_DATA_W       = 32;
  localparam logic        AGE_LIMIT_IDX    = 1'b0;
  localparam logic [15:0] AGE_LIMIT_RESET  = 16'd300;

  // operation codes
  typedef enum logic [1:0] {
    OP_LEARN   = 2'd0,
    OP_RESOLVE = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  // result codes
  typedef enum logic [2:0] {
    KIND_HIT     = 3'd0,
    KIND_QUEUED  = 3'd1,
    KIND_DUP     = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_REQUEST = 3'd4,
    KIND_RELEASE = 3'd5,
    KIND_TIMEOUT = 3'd6
  } kind_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRD,
    ST_CEV,
    ST_CDONE,
    ST_CWR,
    ST_WRD,
    ST_WEV,
    ST_WDONE,
    ST_EMIT
  } state_e;

  // purpose of a cache scan
  typedef enum logic [1:0] {
    CM_LEARN,
    CM_RESOLVE,
    CM_EXPIRE,
    CM_LOOKUP
  } cmode_e;

  // purpose of a pending queue scan
  typedef enum logic [1:0] {
    WM_RELEASE,
    WM_RESOLVE,
    WM_TIMEOUT,
    WM_ADVANCE
  } wmode_e;

  // one cache memory word
  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } cache_word_t;

  // one pending queue memory word
  typedef struct packed {
    logic [IP_W-1:0]     ip;
    logic [HANDLE_W-1:0] handle;
  } wait_word_t;

  // one buffered result
  typedef struct packed {
    kind_e               kind;
    logic [IP_W-1:0]     ip;
    logic [MAC_W-1:0]    mac;
    logic [HANDLE_W-1:0] handle;
  } res_t;

endpackage

/* hw/rtl/arpc_req_if.sv */
// request channel: one operation per transaction
interface arpc_req_if
  import arpc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [IP_W-1:0]     ip;
  logic [MAC_W-1:0]    mac;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, op, ip, mac, handle, input ready);
  modport sink   (input valid, op, ip, mac, handle, output ready);
endinterface

/* hw/rtl/arpc_rsp_if.sv */
// response channel: one result per transaction
interface arpc_rsp_if
  import arpc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [2:0]          kind;
  logic [IP_W-1:0]     out_ip;
  logic [MAC_W-1:0]    out_mac;
  logic [HANDLE_W-1:0] out_handle;
  logic                last;

  modport source (output valid, kind, out_ip, out_mac, out_handle, last, input ready);
  modport sink   (input valid, kind, out_ip, out_mac, out_handle, last, output ready);
endinterface

/* hw/rtl/arp_cache_with_pending_queue.sv */
// arp cache with pending queue: sequencer, cache memory and pending queue memory
//
// usage: req_i carries learn, resolve and tick operations; rsp_o returns up to
// two results per operation, the final one flagged by last. age_limit is set
// through the apb port at byte address 0 and is to be written by the user only
// while the block is idle; the block itself does not enforce this.
// one operation at a time: req_i.ready is high only while the sequencer idles.
// each cache or queue entry visit is a memory read, then an evaluate step.
// resolve scans the cache and, on a miss, the queue; learn scans the cache,
// writes the entry, then scans the queue to release waiting packets and to find
// the next request; tick scans the cache to expire entries, then the queue,
// with a cache lookup scan per busy slot visited, then seeks the next request.
// results go through an output register; a stalled receiver holds it and the
// sequencer waits in its output state, new transactions are taken once all
// results of the current one are in or past the output register.
// reset empties cache and queue (valid and busy flags in flops), clears the
// tick counter and sets age_limit to 300; no memory clearing pass is needed.
module arp_cache_with_pending_queue
  import arpc_pkg::*;
#(
  parameter int unsigned CACHE_ENTRIES = 8,
  parameter int unsigned WAIT_SLOTS    = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  arpc_req_if.sink              req_i,
  arpc_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned WW = (WAIT_SLOTS > 1) ? $clog2(WAIT_SLOTS) : 1;

  // memories
  cache_word_t cache_mem [CACHE_ENTRIES];
  wait_word_t  wait_mem  [WAIT_SLOTS];
  cache_word_t cache_rd_q;
  wait_word_t  wait_rd_q;
  logic        cache_we;
  logic [CW-1:0] cache_wa;
  cache_word_t cache_wd;
  logic        wait_we;
  logic [WW-1:0] wait_wa;
  wait_word_t  wait_wd;

  // control state
  state_e state_q, state_d;
  logic [CACHE_ENTRIES-1:0] cvalid_q, cvalid_d;
  logic [WAIT_SLOTS-1:0]    busy_q, busy_d;
  logic [WW-1:0]            oldest_q, oldest_d;
  logic [STAMP_W-1:0]       now_q, now_d;
  logic [15:0]              limit_q;
  logic                     out_valid_q, out_valid_d;
  logic [1:0]               res_cnt_q, res_cnt_d;
  logic                     res_ptr_q, res_ptr_d;

  // operation and scan registers
  logic [IP_W-1:0]     ip_q, ip_d;
  logic [MAC_W-1:0]    mac_q, mac_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [CW-1:0]       idx_q, idx_d;
  logic [WW-1:0]       off_q, off_d;
  cmode_e              cmode_q, cmode_d;
  wmode_e              wmode_q, wmode_d;
  logic                hit_q, hit_d;
  logic [CW-1:0]       hidx_q, hidx_d;
  logic [MAC_W-1:0]    hmac_q, hmac_d;
  logic                free_q, free_d;
  logic [CW-1:0]       fidx_q, fidx_d;
  logic [AGE_W-1:0]    best_q, best_d;
  logic [CW-1:0]       eidx_q, eidx_d;
  logic                wfound_q, wfound_d;
  logic                wfree_q, wfree_d;
  logic [WW-1:0]       wslot_q, wslot_d;
  logic [IP_W-1:0]     key_q, key_d;
  logic [HANDLE_W-1:0] khandle_q, khandle_d;
  res_t                res_q [2];
  res_t                res_d [2];
  res_t                out_q, out_d;
  logic                out_last_q, out_last_d;

  // derived scan signals
  logic                in_acc;
  logic                out_free;
  logic                c_valid;
  logic                c_last;
  logic [STAMP_W-1:0]  c_age;
  logic [IP_W-1:0]     c_key;
  logic                c_match;
  logic [WW:0]         slot_sum;
  logic [WW-1:0]       slot;
  logic                w_busy;
  logic                w_match;
  logic                w_last;
  logic                no_busy;
  logic [CW-1:0]       victim;
  logic                emit_last;
  logic                cfg_wr;

  function automatic res_t mk_res(kind_e k, logic [IP_W-1:0] a, logic [MAC_W-1:0] m,
                                  logic [HANDLE_W-1:0] h);
    res_t r;
    r.kind   = k;
    r.ip     = a;
    r.mac    = m;
    r.handle = h;
    return r;
  endfunction

  // handshakes
  assign req_i.ready = (state_q == ST_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // cache entry under evaluation
  assign c_valid = cvalid_q[idx_q];
  assign c_last  = (idx_q == CW'(CACHE_ENTRIES - 1));
  assign c_age   = now_q - cache_rd_q.stamp;
  assign c_key   = (cmode_q == CM_LOOKUP) ? key_q : ip_q;
  assign c_match = c_valid && (cache_rd_q.ip == c_key);

  // queue slot under evaluation, counted from the oldest slot
  assign slot_sum = {1'b0, oldest_q} + {1'b0, off_q};
  assign slot     = (slot_sum >= (WW+1)'(WAIT_SLOTS)) ?
                    WW'(slot_sum - (WW+1)'(WAIT_SLOTS)) : WW'(slot_sum);
  assign w_busy   = busy_q[slot];
  assign w_match  = w_busy && (wait_rd_q.ip == ip_q);
  assign w_last   = (off_q == WW'(WAIT_SLOTS - 1));
  assign no_busy  = ~|busy_q;

  // learn target: matching entry, else first free, else oldest by the low AGE_W age bits
  assign victim    = hit_q ? hidx_q : (free_q ? fidx_q : eidx_q);
  assign emit_last = ({1'b0, res_ptr_q} == (res_cnt_q - 2'd1));

  // configuration port
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1:2] == AGE_LIMIT_IDX);
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_W-1:2] == AGE_LIMIT_IDX) ?
                  {{(CFG_DATA_W-16){1'b0}}, limit_q} : '0;

  // response port
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.kind       = out_q.kind;
  assign rsp_o.out_ip     = out_q.ip;
  assign rsp_o.out_mac    = out_q.mac;
  assign rsp_o.out_handle = out_q.handle;
  assign rsp_o.last       = out_last_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (op_e'(req_i.op) != OP_NONE)) state_d = ST_CRD;
      end
      ST_CRD:  state_d = ST_CEV;
      ST_CEV:  state_d = c_last ? ST_CDONE : ST_CRD;
      ST_CDONE: begin
        unique case (cmode_q)
          CM_LEARN:   state_d = ST_CWR;
          CM_RESOLVE: state_d = hit_q ? ST_EMIT : ST_WRD;
          CM_EXPIRE:  state_d = ST_WRD;
          CM_LOOKUP:  state_d = (hit_q && w_last) ? ST_EMIT : ST_WRD;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_CWR:  state_d = ST_WRD;
      ST_WRD:  state_d = ST_WEV;
      ST_WEV: begin
        unique case (wmode_q)
          WM_RELEASE: state_d = ST_WRD;
          WM_RESOLVE: state_d = w_match ? ST_EMIT : (w_last ? ST_WDONE : ST_WRD);
          WM_TIMEOUT: state_d = w_busy ? ST_CRD : (w_last ? ST_EMIT : ST_WRD);
          WM_ADVANCE: state_d = (w_busy || w_last) ? ST_EMIT : ST_WRD;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_WDONE: state_d = ST_EMIT;
      ST_EMIT: begin
        if (res_cnt_q == 2'd0) begin
          state_d = ST_IDLE;
        end else if (out_free && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cvalid_d    = cvalid_q;
    busy_d      = busy_q;
    oldest_d    = oldest_q;
    now_d       = now_q;
    out_valid_d = out_valid_q;
    res_cnt_d   = res_cnt_q;
    res_ptr_d   = res_ptr_q;
    ip_d        = ip_q;
    mac_d       = mac_q;
    handle_d    = handle_q;
    idx_d       = idx_q;
    off_d       = off_q;
    cmode_d     = cmode_q;
    wmode_d     = wmode_q;
    hit_d       = hit_q;
    hidx_d      = hidx_q;
    hmac_d      = hmac_q;
    free_d      = free_q;
    fidx_d      = fidx_q;
    best_d      = best_q;
    eidx_d      = eidx_q;
    wfound_d    = wfound_q;
    wfree_d     = wfree_q;
    wslot_d     = wslot_q;
    key_d       = key_q;
    khandle_d   = khandle_q;
    res_d       = res_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    cache_we    = 1'b0;
    cache_wa    = victim;
    cache_wd    = '{ip: ip_q, mac: mac_q, stamp: now_q};
    wait_we     = 1'b0;
    wait_wa     = wslot_q;
    wait_wd     = '{ip: ip_q, handle: handle_q};

    // output register drains whenever taken
    if (out_valid_q && rsp_o.ready) out_valid_d = 1'b0;

    unique case (state_q)
      // latch the transaction and start the cache scan
      ST_IDLE: begin
        if (in_acc) begin
          ip_d      = req_i.ip;
          mac_d     = req_i.mac;
          handle_d  = req_i.handle;
          idx_d     = '0;
          off_d     = '0;
          res_cnt_d = 2'd0;
          res_ptr_d = 1'b0;
          hit_d     = 1'b0;
          free_d    = 1'b0;
          best_d    = '0;
          eidx_d    = '0;
          hidx_d    = '0;
          fidx_d    = '0;
          wfound_d  = 1'b0;
          wfree_d   = 1'b0;
          unique case (op_e'(req_i.op))
            OP_LEARN:   cmode_d = CM_LEARN;
            OP_RESOLVE: cmode_d = CM_RESOLVE;
            OP_TICK: begin
              cmode_d = CM_EXPIRE;
              now_d   = now_q + 16'd1;
            end
            default:    cmode_d = cmode_q;
          endcase
        end
      end
      ST_CRD: ;
      // evaluate one cache entry
      ST_CEV: begin
        unique case (cmode_q)
          CM_LEARN: begin
            if (c_match && !hit_q) begin
              hit_d  = 1'b1;
              hidx_d = idx_q;
            end
            if (!c_valid && !free_q) begin
              free_d = 1'b1;
              fidx_d = idx_q;
            end
            if (c_age[AGE_W-1:0] > best_q) begin
              best_d = c_age[AGE_W-1:0];
              eidx_d = idx_q;
            end
          end
          CM_RESOLVE: begin
            if (c_match && !hit_q) begin
              hit_d  = 1'b1;
              hmac_d = cache_rd_q.mac;
            end
          end
          CM_EXPIRE: begin
            if (c_valid && (c_age >= limit_q)) cvalid_d[idx_q] = 1'b0;
          end
          CM_LOOKUP: begin
            if (c_match) hit_d = 1'b1;
          end
          default: ;
        endcase
        if (!c_last) idx_d = idx_q + CW'(1);
      end
      // act on the finished cache scan
      ST_CDONE: begin
        unique case (cmode_q)
          CM_LEARN: ;
          CM_RESOLVE: begin
            if (hit_q) begin
              res_d[0]  = mk_res(KIND_HIT, ip_q, hmac_q, '0);
              res_cnt_d = 2'd1;
            end else begin
              off_d   = '0;
              wmode_d = WM_RESOLVE;
            end
          end
          CM_EXPIRE: begin
            off_d   = '0;
            wmode_d = WM_TIMEOUT;
          end
          CM_LOOKUP: begin
            if (hit_q) begin
              if (!w_last) off_d = off_q + WW'(1);
            end else begin
              busy_d[wslot_q] = 1'b0;
              res_d[res_cnt_q[0]] = mk_res(KIND_TIMEOUT, key_q, '0, khandle_q);
              res_cnt_d = res_cnt_q + 2'd1;
              off_d     = '0;
              wmode_d   = WM_ADVANCE;
            end
          end
          default: ;
        endcase
      end
      // store the learned mapping
      ST_CWR: begin
        cache_we         = 1'b1;
        cvalid_d[victim] = 1'b1;
        off_d            = '0;
        wmode_d          = WM_RELEASE;
      end
      ST_WRD: ;
      // evaluate one queue slot
      ST_WEV: begin
        unique case (wmode_q)
          WM_RELEASE: begin
            if (w_match) begin
              if (!wfound_q) begin
                res_d[res_cnt_q[0]] = mk_res(KIND_RELEASE, ip_q, mac_q, wait_rd_q.handle);
                res_cnt_d = res_cnt_q + 2'd1;
                wfound_d  = 1'b1;
              end
              busy_d[slot] = 1'b0;
            end
            if (w_last) begin
              off_d   = '0;
              wmode_d = WM_ADVANCE;
            end else begin
              off_d = off_q + WW'(1);
            end
          end
          WM_RESOLVE: begin
            if (w_match) begin
              res_d[0]  = mk_res(KIND_DUP, ip_q, '0, handle_q);
              res_cnt_d = 2'd1;
            end else begin
              if (!w_busy && !wfree_q) begin
                wfree_d = 1'b1;
                wslot_d = slot;
              end
              if (!w_last) off_d = off_q + WW'(1);
            end
          end
          WM_TIMEOUT: begin
            if (w_busy) begin
              key_d     = wait_rd_q.ip;
              khandle_d = wait_rd_q.handle;
              wslot_d   = slot;
              idx_d     = '0;
              hit_d     = 1'b0;
              cmode_d   = CM_LOOKUP;
            end else if (!w_last) begin
              off_d = off_q + WW'(1);
            end
          end
          WM_ADVANCE: begin
            if (w_busy) begin
              res_d[res_cnt_q[0]] = mk_res(KIND_REQUEST, wait_rd_q.ip, '0, '0);
              res_cnt_d = res_cnt_q + 2'd1;
              oldest_d  = slot;
            end else if (w_last) begin
              oldest_d = '0;
            end else begin
              off_d = off_q + WW'(1);
            end
          end
          default: ;
        endcase
      end
      // queue the handle or drop it
      ST_WDONE: begin
        if (wfree_q) begin
          wait_we         = 1'b1;
          busy_d[wslot_q] = 1'b1;
          res_d[0]        = mk_res(KIND_QUEUED, ip_q, '0, handle_q);
          if (no_busy) begin
            res_d[1]  = mk_res(KIND_REQUEST, ip_q, '0, '0);
            res_cnt_d = 2'd2;
            oldest_d  = wslot_q;
          end else begin
            res_cnt_d = 2'd1;
          end
        end else begin
          res_d[0]  = mk_res(KIND_FULL, ip_q, '0, handle_q);
          res_cnt_d = 2'd1;
        end
      end
      // hand results to the output register
      ST_EMIT: begin
        if ((res_cnt_q != 2'd0) && out_free) begin
          out_d       = res_q[res_ptr_q];
          out_last_d  = emit_last;
          out_valid_d = 1'b1;
          res_ptr_d   = res_ptr_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memories with registered read
  always_ff @(posedge clk_i) begin
    if (cache_we) cache_mem[cache_wa] <= cache_wd;
    cache_rd_q <= cache_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (wait_we) wait_mem[wait_wa] <= wait_wd;
    wait_rd_q <= wait_mem[slot];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cvalid_q    <= '0;
      busy_q      <= '0;
      oldest_q    <= '0;
      now_q       <= '0;
      limit_q     <= AGE_LIMIT_RESET;
      out_valid_q <= 1'b0;
      res_cnt_q   <= 2'd0;
      res_ptr_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      cvalid_q    <= cvalid_d;
      busy_q      <= busy_d;
      oldest_q    <= oldest_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
      res_cnt_q   <= res_cnt_d;
      res_ptr_q   <= res_ptr_d;
      if (cfg_wr) limit_q <= pwdata[15:0];
    end
  end

  // payload and scan registers
  always_ff @(posedge clk_i) begin
    ip_q       <= ip_d;
    mac_q      <= mac_d;
    handle_q   <= handle_d;
    idx_q      <= idx_d;
    off_q      <= off_d;
    cmode_q    <= cmode_d;
    wmode_q    <= wmode_d;
    hit_q      <= hit_d;
    hidx_q     <= hidx_d;
    hmac_q     <= hmac_d;
    free_q     <= free_d;
    fidx_q     <= fidx_d;
    best_q     <= best_d;
    eidx_q     <= eidx_d;
    wfound_q   <= wfound_d;
    wfree_q    <= wfree_d;
    wslot_q    <= wslot_d;
    key_q      <= key_d;
    khandle_q  <= khandle_d;
    res_q      <= res_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

endmodule

/* hw/rtl/arpc_checker.sv */
// port-level assertions for the arp cache, bound to the top level
module arpc_checker
  import arpc_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic [1:0]          in_op_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [2:0]          kind_i,
  input logic [IP_W-1:0]     out_ip_i,
  input logic [MAC_W-1:0]    out_mac_i,
  input logic [HANDLE_W-1:0] out_handle_i,
  input logic                last_i
);

  // an accepted operation keeps the sequencer busy: ready is low in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i != OP_NONE) |=> !in_ready_i)
    else $error("request ready right after a transaction");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(out_ip_i) && $stable(last_i))
    else $error("stalled result changed");

  // a send request carries no mac and no handle
  a_request_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_REQUEST) |-> (out_mac_i == '0) && (out_handle_i == '0))
    else $error("send request with mac or handle");

  // a cache hit is the only result of its transaction
  a_hit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_HIT) |-> last_i)
    else $error("hit result not final");

endmodule

bind arp_cache_with_pending_queue arpc_checker u_arpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .in_op_i      (req_i.op),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .kind_i       (rsp_o.kind),
  .out_ip_i     (rsp_o.out_ip),
  .out_mac_i    (rsp_o.out_mac),
  .out_handle_i (rsp_o.out_handle),
  .last_i       (rsp_o.last)
);

/* tb/sv/tb_arp_cache_with_pending_queue.sv */
// testbench of the arp cache with pending queue: directed table, random phases, predictor check
`timescale 1ns / 1ps

module tb_arp_cache_with_pending_queue;
  import arpc_pkg::*;

  localparam int unsigned N_CACHE     = 8;
  localparam int unsigned N_WAIT      = 4;
  localparam int unsigned SETTLE_CYC  = 300;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_ITEMS = 140;

  // one expected result
  typedef struct {
    kind_e               kind;
    logic [IP_W-1:0]     ip;
    logic [MAC_W-1:0]    mac;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } arp_res_t;

  // one directed row; the typed expectation is checked only where chk is set
  typedef struct {
    op_e                 op;
    logic [IP_W-1:0]     ip;
    logic [MAC_W-1:0]    mac;
    logic [HANDLE_W-1:0] handle;
    bit                  chk;
    int                  n_res;
    kind_e               first_kind;
  } arp_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  arpc_req_if req ();
  arpc_rsp_if rsp ();

  arp_cache_with_pending_queue #(
    .CACHE_ENTRIES(N_CACHE),
    .WAIT_SLOTS   (N_WAIT)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [IP_W-1:0]     cache_ip    [N_CACHE];
  logic [MAC_W-1:0]    cache_mac   [N_CACHE];
  logic [STAMP_W-1:0]  cache_stamp [N_CACHE];
  bit                  cache_vld   [N_CACHE];
  logic [IP_W-1:0]     pend_ip     [N_WAIT];
  logic [HANDLE_W-1:0] pend_handle [N_WAIT];
  bit                  pend_busy   [N_WAIT];
  int unsigned         pend_head;
  logic [STAMP_W-1:0]  tick_now;
  logic [15:0]         age_lim;

  arp_res_t    results_due[$];
  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned kind_seen [7];
  int unsigned cycles = 0;
  bit          calm_send = 1'b0;
  bit          calm_recv = 1'b0;
  logic [IP_W-1:0] ip_pool [12];

  task automatic report(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic void predictor_reset();
    for (int i = 0; i < N_CACHE; i++) begin
      cache_ip[i] = '0; cache_mac[i] = '0; cache_stamp[i] = '0; cache_vld[i] = 1'b0;
    end
    for (int s = 0; s < N_WAIT; s++) begin
      pend_ip[s] = '0; pend_handle[s] = '0; pend_busy[s] = 1'b0;
    end
    pend_head = 0;
    tick_now = '0;
    age_lim = AGE_LIMIT_RESET;
  endfunction

  function automatic bit lookup(input logic [IP_W-1:0] ip, output int where);
    where = 0;
    for (int i = 0; i < N_CACHE; i++) begin
      if (cache_vld[i] && cache_ip[i] == ip) begin
        where = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic arp_res_t mk(input kind_e k, input logic [IP_W-1:0] ip,
                                  input logic [MAC_W-1:0] mac,
                                  input logic [HANDLE_W-1:0] h);
    arp_res_t r;
    r.kind = k; r.ip = ip; r.mac = mac; r.handle = h; r.last = 1'b0;
    return r;
  endfunction

  // move the queue head to the first busy slot and request it
  function automatic void advance_head(ref arp_res_t res[$]);
    int unsigned s;
    for (int off = 0; off < N_WAIT; off++) begin
      s = (pend_head + off) % N_WAIT;
      if (pend_busy[s]) begin
        pend_head = s;
        res.push_back(mk(KIND_REQUEST, pend_ip[s], '0, '0));
        return;
      end
    end
    pend_head = 0;
  endfunction

  // expected results of one accepted operation
  function automatic void predict_arp_op(input logic [1:0] op, input logic [IP_W-1:0] ip,
                                         input logic [MAC_W-1:0] mac,
                                         input logic [HANDLE_W-1:0] h,
                                         ref arp_res_t res[$]);
    int k;
    int unsigned s;
    logic [AGE_W-1:0] best, age;
    bit found, only;
    res.delete();
    case (op)
      OP_LEARN: begin
        if (!lookup(ip, k)) begin
          found = 1'b0;
          for (int i = 0; i < N_CACHE; i++) begin
            if (!found && !cache_vld[i]) begin
              k = i; found = 1'b1;
            end
          end
          if (!found) begin
            best = '0; k = 0;
            for (int i = 0; i < N_CACHE; i++) begin
              age = AGE_W'(tick_now - cache_stamp[i]);
              if (age > best) begin
                best = age; k = i;
              end
            end
          end
          cache_ip[k] = ip;
          cache_vld[k] = 1'b1;
        end
        cache_mac[k] = mac;
        cache_stamp[k] = tick_now;
        // release every waiting packet for this address, report the first
        for (int off = 0; off < N_WAIT; off++) begin
          s = (pend_head + off) % N_WAIT;
          if (pend_busy[s] && pend_ip[s] == ip) begin
            if (res.size() == 0) res.push_back(mk(KIND_RELEASE, ip, mac, pend_handle[s]));
            pend_busy[s] = 1'b0; pend_ip[s] = '0; pend_handle[s] = '0;
          end
        end
        advance_head(res);
      end
      OP_RESOLVE: begin
        if (lookup(ip, k)) begin
          res.push_back(mk(KIND_HIT, ip, cache_mac[k], '0));
        end else begin
          for (int off = 0; off < N_WAIT; off++) begin
            s = (pend_head + off) % N_WAIT;
            if (res.size() == 0 && pend_busy[s] && pend_ip[s] == ip)
              res.push_back(mk(KIND_DUP, ip, '0, h));
          end
          for (int off = 0; off < N_WAIT; off++) begin
            s = (pend_head + off) % N_WAIT;
            if (res.size() == 0 && !pend_busy[s]) begin
              pend_busy[s] = 1'b1; pend_ip[s] = ip; pend_handle[s] = h;
              only = 1'b1;
              for (int i = 0; i < N_WAIT; i++)
                if (i != s && pend_busy[i]) only = 1'b0;
              res.push_back(mk(KIND_QUEUED, ip, '0, h));
              if (only) begin
                pend_head = s;
                res.push_back(mk(KIND_REQUEST, ip, '0, '0));
              end
            end
          end
          if (res.size() == 0) res.push_back(mk(KIND_FULL, ip, '0, h));
        end
      end
      OP_TICK: begin
        tick_now = tick_now + 1'b1;
        for (int i = 0; i < N_CACHE; i++) begin
          if (cache_vld[i] && STAMP_W'(tick_now - cache_stamp[i]) >= age_lim) begin
            cache_vld[i] = 1'b0; cache_ip[i] = '0; cache_mac[i] = '0; cache_stamp[i] = '0;
          end
        end
        // first waiting packet whose address is not cached times out
        for (int off = 0; off < N_WAIT; off++) begin
          s = (pend_head + off) % N_WAIT;
          if (res.size() == 0 && pend_busy[s] && !lookup(pend_ip[s], k)) begin
            res.push_back(mk(KIND_TIMEOUT, pend_ip[s], '0, pend_handle[s]));
            pend_busy[s] = 1'b0; pend_ip[s] = '0; pend_handle[s] = '0;
            advance_head(res);
          end
        end
      end
      default: ;
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
  endfunction

  // drive one operation and log its expected results at acceptance
  task automatic send_op(input logic [1:0] op, input logic [IP_W-1:0] ip,
                         input logic [MAC_W-1:0] mac, input logic [HANDLE_W-1:0] h,
                         input bit chk, input int n_res, input kind_e first_kind);
    arp_res_t res[$];
    int unsigned gap;
    gap = calm_send ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.op <= op; req.ip <= ip; req.mac <= mac; req.handle <= h;
    do @(posedge clk_i); while (!(req.valid && req.ready));
    predict_arp_op(op, ip, mac, h, res);
    if (chk && (res.size() != n_res || (n_res > 0 && res[0].kind != first_kind)))
      report($sformatf("directed op %0d ip %h: predictor gives %0d results", op, ip,
                       res.size()));
    foreach (res[i]) results_due.push_back(res[i]);
    items_sent++;
  endtask

  // wait for all results, then for the block to settle
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                          input logic [CFG_DATA_W-1:0] data,
                          output logic [CFG_DATA_W-1:0] rd);
    psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_age_limit(input logic [15:0] lim);
    logic [CFG_DATA_W-1:0] rd;
    apb_xfer(1'b1, CFG_ADDR_W'(AGE_LIMIT_IDX) << 2, CFG_DATA_W'(lim), rd);
    age_lim = lim;
    apb_xfer(1'b0, CFG_ADDR_W'(AGE_LIMIT_IDX) << 2, '0, rd);
    if (rd !== CFG_DATA_W'(lim)) report($sformatf("age_limit reads %h, want %h", rd, lim));
  endtask

  function automatic logic [IP_W-1:0] pick_ip();
    return ($urandom_range(0, 4) == 0) ? IP_W'($urandom) : ip_pool[$urandom_range(0, 11)];
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    arp_res_t w;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (results_due.size() == 0) begin
        report($sformatf("unexpected result kind %0d ip %h", rsp.kind, rsp.out_ip));
      end else begin
        w = results_due.pop_front();
        if (rsp.kind < 7) kind_seen[rsp.kind]++;
        if (rsp.kind !== w.kind)
          report($sformatf("kind %0d, want %0d", rsp.kind, w.kind));
        if (rsp.out_ip !== w.ip)
          report($sformatf("out_ip %h, want %h", rsp.out_ip, w.ip));
        if (rsp.out_mac !== w.mac)
          report($sformatf("out_mac %h, want %h", rsp.out_mac, w.mac));
        if (rsp.out_handle !== w.handle)
          report($sformatf("out_handle %h, want %h", rsp.out_handle, w.handle));
        if (rsp.last !== w.last)
          report($sformatf("last %b, want %b", rsp.last, w.last));
      end
    end
  end

  // receiver stalls
  initial begin
    int unsigned stall;
    rsp.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = calm_recv ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp.valid && rsp.ready));
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               results_due.size());
      $display("tb_arp_cache_with_pending_queue: done, errors");
      $finish;
    end
  end

  initial begin
    arp_row_t rows[$];
    logic [15:0] limits [5] = '{16'd300, 16'd1, 16'd4, 16'd65535, 16'd12};
    logic [CFG_DATA_W-1:0] rd;
    int unsigned sel;
    logic [1:0] op;

    req.valid = 1'b0; req.op = OP_NONE; req.ip = '0; req.mac = '0; req.handle = '0;
    ip_pool[0] = '0;
    ip_pool[1] = '1;
    for (int i = 2; i < 12; i++) ip_pool[i] = IP_W'($urandom);
    predictor_reset();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: queue fill, duplicate, full, release, hit, timeout, eviction
    rows.push_back('{OP_RESOLVE, 32'h0, 48'h0, 8'h00, 1, 2, KIND_QUEUED});
    rows.push_back('{OP_RESOLVE, 32'h0, 48'h0, 8'h05, 1, 1, KIND_DUP});
    rows.push_back('{OP_RESOLVE, 32'hFFFF_FFFF, 48'h0, 8'hFF, 1, 1, KIND_QUEUED});
    rows.push_back('{OP_RESOLVE, 32'h1, 48'h0, 8'h01, 1, 1, KIND_QUEUED});
    rows.push_back('{OP_RESOLVE, 32'h2, 48'h0, 8'h02, 1, 1, KIND_QUEUED});
    rows.push_back('{OP_RESOLVE, 32'h3, 48'h0, 8'h03, 1, 1, KIND_FULL});
    rows.push_back('{OP_LEARN, 32'h0, 48'hFFFF_FFFF_FFFF, 8'hAA, 1, 2, KIND_RELEASE});
    rows.push_back('{OP_RESOLVE, 32'h0, 48'h0, 8'h77, 1, 1, KIND_HIT});
    rows.push_back('{OP_TICK, 32'h0, 48'h0, 8'h00, 1, 2, KIND_TIMEOUT});
    rows.push_back('{OP_NONE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 8'hFF, 1, 0, KIND_HIT});
    rows.push_back('{OP_LEARN, 32'h1, 48'h0, 8'h00, 0, 0, KIND_HIT});
    rows.push_back('{OP_LEARN, 32'h2, 48'h1234_5678_9ABC, 8'h00, 0, 0, KIND_HIT});
    rows.push_back('{OP_TICK, 32'h0, 48'h0, 8'h00, 1, 0, KIND_HIT});
    rows.push_back('{OP_LEARN, 32'h0, 48'hA5A5_5A5A_A5A5, 8'h00, 1, 0, KIND_HIT});
    for (int i = 0; i < 7; i++)
      rows.push_back('{OP_LEARN, 32'h0A00_0010 + i, 48'h0000_0000_1000 + i, 8'h00, 1, 0,
                       KIND_HIT});
    rows.push_back('{OP_RESOLVE, 32'h2, 48'h0, 8'h10, 1, 2, KIND_QUEUED});
    rows.push_back('{OP_TICK, 32'h0, 48'h0, 8'h00, 1, 1, KIND_TIMEOUT});
    rows.push_back('{OP_RESOLVE, 32'h0A00_0016, 48'h0, 8'h11, 1, 1, KIND_HIT});
    foreach (rows[i])
      send_op(rows[i].op, rows[i].ip, rows[i].mac, rows[i].handle, rows[i].chk,
              rows[i].n_res, rows[i].first_kind);
    drain();

    // a write past the only register is ignored
    apb_xfer(1'b1, CFG_ADDR_W'(4), 32'h0000_0001, rd);
    apb_xfer(1'b0, CFG_ADDR_W'(0), '0, rd);
    if (rd !== CFG_DATA_W'(age_lim)) report($sformatf("age_limit reads %h after stray write", rd));

    // random phases, one age limit each
    foreach (limits[p]) begin
      if (p > 0) set_age_limit(limits[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 35 == 0) begin
          calm_send = ($urandom_range(0, 3) == 0);
          calm_recv = ($urandom_range(0, 3) == 0);
        end
        sel = $urandom_range(0, 99);
        op = (sel < 30) ? OP_LEARN : (sel < 70) ? OP_RESOLVE : (sel < 95) ? OP_TICK : OP_NONE;
        send_op(op, pick_ip(), MAC_W'({$urandom, $urandom}),
                HANDLE_W'($urandom), 1'b0, 0, KIND_HIT);
      end
      drain();
    end

    $display("covered %0d operations over five age limits; results hit %0d queued %0d dup %0d",
             items_sent, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("full %0d request %0d release %0d timeout %0d, %0d mismatches",
             kind_seen[3], kind_seen[4], kind_seen[5], kind_seen[6], err_count);
    if (err_count == 0) begin
      $display("tb_arp_cache_with_pending_queue: done, clean");
    end else begin
      $display("tb_arp_cache_with_pending_queue: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_req_if.sv
hw/rtl/arpc_rsp_if.sv
hw/rtl/arp_cache_with_pending_queue.sv
hw/rtl/arpc_checker.sv
tb/sv/tb_arp_cache_with_pending_queue.sv
